[rtl/quantized_position_bounding_box_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quantized position bounding box block
// Shared property forms used by the RTL files that carry assertions.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_POSITION_BOUNDING_BOX_DEFINES_SVH
`define QUANTIZED_POSITION_BOUNDING_BOX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPBB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QPBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/qpbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpbb_pkg
// Types and constants of the quantized position bounding box block.
// ----------------------------------------------------------------------------
package qpbb_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned Q_W           = 16;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned NUM_AXES      = 3;
    localparam int unsigned CFG_IDX_W     = 3;

    // Dequantization divisor and its rounding bias.
    localparam int unsigned QDIV     = 32767;
    localparam int unsigned RND_HALF = QDIV / 2;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X  = 3'd0,
        CFG_SCALE_Y  = 3'd1,
        CFG_SCALE_Z  = 3'd2,
        CFG_OFFSET_X = 3'd3,
        CFG_OFFSET_Y = 3'd4,
        CFG_OFFSET_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
        logic signed [Q_W-1:0] qz;
        logic                  last;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

endpackage

[rtl/qpbb_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpbb_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface qpbb_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/quantized_position_bounding_box.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_position_bounding_box
// Dequantizes int16 vertices per axis and tracks the box of each chunk.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              item
//  i_vtx     in   qx, qy, qz (s16), last               one vertex
//  o_box     out  min_x..z, max_x..z (s32 Q16.16)      one box per chunk
//  i_cfg_*   in   we, idx (3b), data (32b)             one register write
//
//  One vertex is accepted every cycle unless the pipe stalls; its value
//  passes through the multiply / divide-by-32767 pipe and then folds into
//  the running box. A box is loaded into the output register on the edge
//  at which its last vertex folds. The pipe stalls only when a last vertex
//  reaches the fold stage while the previous box has not been taken. Reset
//  is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "quantized_position_bounding_box_defines.svh"

module quantized_position_bounding_box #(
    parameter int unsigned FRAC_BITS = qpbb_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qpbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qpbb_pkg::COORD_W-1:0]    i_cfg_data,
    qpbb_stream_if.sink                     i_vtx,
    qpbb_stream_if.source                   o_box
);
    import qpbb_pkg::*;

    localparam int unsigned PROD_W = Q_W + COORD_W;   // signed product
    localparam int unsigned MAG_W  = PROD_W - 1;      // magnitude plus bias
    localparam int unsigned QUO_W  = COORD_W + 1;     // unsigned quotient
    localparam int unsigned REM_W  = 18;              // remainder below 4*QDIV
    localparam int unsigned DSH    = 15;              // QDIV = 2^DSH - 1
    localparam int unsigned SUM_W  = COORD_W + 3;

    localparam logic signed [COORD_W-1:0] SCALE_ONE = COORD_W'(64'd1 << FRAC_BITS);

    // Configuration registers.
    logic signed [COORD_W-1:0] r_scale  [NUM_AXES];
    logic signed [COORD_W-1:0] r_offset [NUM_AXES];

    // Pipeline stages.
    logic                      r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic                      r_s1_last, r_s2_last, r_s3_last, r_s4_last, r_s5_last, r_s6_last;
    logic signed [Q_W-1:0]     r_s1_q    [NUM_AXES];
    logic signed [PROD_W-1:0]  r_s2_prod [NUM_AXES];
    logic [MAG_W-1:0]          r_s3_mag  [NUM_AXES];
    logic [NUM_AXES-1:0]       r_s3_neg, r_s4_neg, r_s5_neg;
    logic [QUO_W-1:0]          r_s4_est  [NUM_AXES];
    logic [REM_W-1:0]          r_s4_mlo  [NUM_AXES];
    logic [QUO_W-1:0]          r_s5_quo  [NUM_AXES];
    logic signed [COORD_W-1:0] r_s6_v    [NUM_AXES];

    // Running box and output register.
    logic signed [COORD_W-1:0] r_min [NUM_AXES];
    logic signed [COORD_W-1:0] r_max [NUM_AXES];
    logic                      r_out_vld;
    t_box                      r_out;

    logic                      w_en;
    logic                      w_fold;
    t_vertex                   w_vtx;
    logic signed [PROD_W-1:0]  n_prod [NUM_AXES];
    logic [MAG_W-1:0]          n_mag  [NUM_AXES];
    logic [QUO_W-1:0]          n_est  [NUM_AXES];
    logic [QUO_W-1:0]          n_quo  [NUM_AXES];
    logic signed [COORD_W-1:0] n_v    [NUM_AXES];
    logic signed [COORD_W-1:0] n_min  [NUM_AXES];
    logic signed [COORD_W-1:0] n_max  [NUM_AXES];
    logic signed [COORD_W-1:0] n_scale  [NUM_AXES];
    logic signed [COORD_W-1:0] n_offset [NUM_AXES];
    logic                      n_out_vld;

    // The whole pipe holds only when a finished box cannot leave.
    assign w_en   = !(r_s6_vld && r_s6_last && r_out_vld && !o_box.ready);
    assign w_fold = w_en && r_s6_vld;
    assign w_vtx  = i_vtx.data;

    assign i_vtx.ready = w_en;
    assign o_box.valid = r_out_vld;
    assign o_box.data  = r_out;

    // Register writes.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_scale[a]  = r_scale[a];
            n_offset[a] = r_offset[a];
        end
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_X:  n_scale[0]  = i_cfg_data;
                CFG_SCALE_Y:  n_scale[1]  = i_cfg_data;
                CFG_SCALE_Z:  n_scale[2]  = i_cfg_data;
                CFG_OFFSET_X: n_offset[0] = i_cfg_data;
                CFG_OFFSET_Y: n_offset[1] = i_cfg_data;
                CFG_OFFSET_Z: n_offset[2] = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath per axis.
    always_comb begin
        logic [PROD_W-1:0] abs_prod;
        logic [REM_W-1:0]  rem;
        logic [1:0]        fix;
        logic signed [SUM_W-1:0] sum;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_prod[a] = PROD_W'(r_s1_q[a]) * PROD_W'(r_scale[a]);

            abs_prod = r_s2_prod[a][PROD_W-1] ? PROD_W'(-r_s2_prod[a])
                                              : PROD_W'(r_s2_prod[a]);
            n_mag[a] = abs_prod[MAG_W-1:0] + MAG_W'(RND_HALF);

            // m / (2^15 - 1) ~ m>>15 + m>>30 + m>>45, at most three short.
            n_est[a] = QUO_W'(r_s3_mag[a] >> DSH) + QUO_W'(r_s3_mag[a] >> (2 * DSH))
                     + QUO_W'(r_s3_mag[a] >> (3 * DSH));

            // Remainder of the estimate is small, so only its low bits are needed.
            rem = r_s4_mlo[a] - REM_W'(r_s4_est[a] << DSH) + r_s4_est[a][REM_W-1:0];
            fix = 2'(rem >= REM_W'(QDIV)) + 2'(rem >= REM_W'(2 * QDIV))
                + 2'(rem >= REM_W'(3 * QDIV));
            n_quo[a] = r_s4_est[a] + QUO_W'(fix);

            sum = r_s5_neg[a] ? -SUM_W'(r_s5_quo[a]) : SUM_W'(r_s5_quo[a]);
            sum = sum + SUM_W'(r_offset[a]);
            if (sum > SUM_W'(COORD_MAX)) begin
                n_v[a] = COORD_MAX;
            end else if (sum < SUM_W'(COORD_MIN)) begin
                n_v[a] = COORD_MIN;
            end else begin
                n_v[a] = sum[COORD_W-1:0];
            end

            n_min[a] = (r_s6_v[a] < r_min[a]) ? r_s6_v[a] : r_min[a];
            n_max[a] = (r_s6_v[a] > r_max[a]) ? r_s6_v[a] : r_max[a];
        end
    end

    always_comb begin
        n_out_vld = r_out_vld && !o_box.ready;
        if (w_fold && r_s6_last) begin
            n_out_vld = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_scale[a]  <= SCALE_ONE;
                r_offset[a] <= '0;
                r_min[a]    <= COORD_MAX;
                r_max[a]    <= COORD_MIN;
            end
        end else begin
            r_out_vld <= n_out_vld;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_scale[a]  <= n_scale[a];
                r_offset[a] <= n_offset[a];
            end
            if (w_en) begin
                r_s1_vld <= i_vtx.valid;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
                r_s4_vld <= r_s3_vld;
                r_s5_vld <= r_s4_vld;
                r_s6_vld <= r_s5_vld;
            end
            if (w_fold) begin
                // A last vertex closes the box and re-arms the running extremes.
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_min[a] <= r_s6_last ? COORD_MAX : n_min[a];
                    r_max[a] <= r_s6_last ? COORD_MIN : n_max[a];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_q[0]  <= w_vtx.qx;
            r_s1_q[1]  <= w_vtx.qy;
            r_s1_q[2]  <= w_vtx.qz;
            r_s1_last  <= w_vtx.last;
            r_s2_last  <= r_s1_last;
            r_s3_last  <= r_s2_last;
            r_s4_last  <= r_s3_last;
            r_s5_last  <= r_s4_last;
            r_s6_last  <= r_s5_last;
            r_s4_neg   <= r_s3_neg;
            r_s5_neg   <= r_s4_neg;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s2_prod[a] <= n_prod[a];
                r_s3_mag[a]  <= n_mag[a];
                r_s3_neg[a]  <= r_s2_prod[a][PROD_W-1];
                r_s4_est[a]  <= n_est[a];
                r_s4_mlo[a]  <= r_s3_mag[a][REM_W-1:0];
                r_s5_quo[a]  <= n_quo[a];
                r_s6_v[a]    <= n_v[a];
            end
        end
        if (w_fold && r_s6_last) begin
            r_out.min_x <= n_min[0];
            r_out.min_y <= n_min[1];
            r_out.min_z <= n_min[2];
            r_out.max_x <= n_max[0];
            r_out.max_y <= n_max[1];
            r_out.max_z <= n_max[2];
        end
    end

    // A new box appears only right after a last vertex was folded.
    `QPBB_ASSERT_NEXT(a_box_from_last, i_clk, i_rst_n,
        !(w_fold && r_s6_last) && !(r_out_vld && !o_box.ready), !r_out_vld,
        "box shown without a last vertex")

    // Every box covers at least one vertex, so its extremes are ordered.
    `QPBB_ASSERT_SAME(a_box_ordered, i_clk, i_rst_n, r_out_vld,
        (r_out.min_x <= r_out.max_x) && (r_out.min_y <= r_out.max_y)
            && (r_out.min_z <= r_out.max_z),
        "box minimum above maximum")

    // Closing a chunk re-arms the running extremes.
    `QPBB_ASSERT_NEXT(a_rearm, i_clk, i_rst_n, w_fold && r_s6_last,
        (r_min[0] == COORD_MAX) && (r_max[0] == COORD_MIN)
            && (r_min[2] == COORD_MAX) && (r_max[2] == COORD_MIN),
        "running box not re-armed")

endmodule

[dv/quantized_position_bounding_box_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_position_bounding_box_tb
// Streams quantized vertices through the block under several dequantization
// settings and idle patterns. Each chunk's box is predicted in a scoreboard
// and compared field by field with the box that the block hands out.
// ----------------------------------------------------------------------------
module quantized_position_bounding_box_tb;
    import qpbb_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PHASE_ITEMS   = 190;
    localparam int          PRESSURE_ITEMS = 110;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          MAX_PRINTS    = 100;
    localparam longint      DIVISOR       = 32767;
    localparam longint      DIV_HALF      = DIVISOR / 2;
    localparam logic [31:0] ONE_FIXED     = 32'h0001_0000;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // Kinds of dequantization setting used by the random phases.
    localparam int SET_UNITY    = 0;
    localparam int SET_RANDOM   = 1;
    localparam int SET_EXTREME  = 2;
    localparam int SET_MODERATE = 3;

    class chunk_box_tracker;
        logic signed [COORD_W-1:0] scale [NUM_AXES];
        logic signed [COORD_W-1:0] offset [NUM_AXES];
        logic signed [COORD_W-1:0] run_min [NUM_AXES];
        logic signed [COORD_W-1:0] run_max [NUM_AXES];
        t_box                      boxes_due [$];
        int unsigned               errors;

        function new();
            errors = 0;
            for (int a = 0; a < NUM_AXES; a++) begin
                scale[a]  = ONE_FIXED;
                offset[a] = '0;
            end
            rearm();
        endfunction

        function void rearm();
            for (int a = 0; a < NUM_AXES; a++) begin
                run_min[a] = COORD_MAX;
                run_max[a] = COORD_MIN;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] d);
            case (idx)
                CFG_SCALE_X:  scale[0]  = d;
                CFG_SCALE_Y:  scale[1]  = d;
                CFG_SCALE_Z:  scale[2]  = d;
                CFG_OFFSET_X: offset[0] = d;
                CFG_OFFSET_Y: offset[1] = d;
                CFG_OFFSET_Z: offset[2] = d;
                default: ;
            endcase
        endfunction

        // Rounds the magnitude of q*scale/32767 to nearest, then applies the sign,
        // adds the offset and clamps to the 32-bit range.
        function logic signed [COORD_W-1:0] dequantize(logic signed [Q_W-1:0] q,
                                                       logic signed [COORD_W-1:0] s,
                                                       logic signed [COORD_W-1:0] o);
            longint          prod;
            longint          quo;
            longint          total;
            longint unsigned mag;
            longint unsigned rq;
            prod  = longint'(q) * longint'(s);
            mag   = (prod < 0) ? longint'(-prod) : prod;
            rq    = (mag + DIV_HALF) / DIVISOR;
            quo   = (prod < 0) ? -longint'(rq) : longint'(rq);
            total = quo + longint'(o);
            if (total > longint'(COORD_MAX)) return COORD_MAX;
            if (total < longint'(COORD_MIN)) return COORD_MIN;
            return total[COORD_W-1:0];
        endfunction

        function void note_vertex(t_vertex v);
            logic signed [Q_W-1:0]     q [NUM_AXES];
            logic signed [COORD_W-1:0] val;
            t_box                      box;
            q = '{v.qx, v.qy, v.qz};
            for (int a = 0; a < NUM_AXES; a++) begin
                val = dequantize(q[a], scale[a], offset[a]);
                if (val < run_min[a]) run_min[a] = val;
                if (val > run_max[a]) run_max[a] = val;
            end
            if (v.last) begin
                box.min_x = run_min[0];
                box.min_y = run_min[1];
                box.min_z = run_min[2];
                box.max_x = run_max[0];
                box.max_y = run_max[1];
                box.max_z = run_max[2];
                boxes_due = {boxes_due, box};
                rearm();
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_box(t_box got);
            t_box        want;
            logic [31:0] g [6];
            logic [31:0] w [6];
            string       names [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
            if (boxes_due.size() == 0) begin
                report_mismatch($sformatf("box with no chunk pending, min_x %0d",
                                          $signed(got.min_x)));
                return;
            end
            want = boxes_due.pop_front();
            g = '{got.min_x, got.min_y, got.min_z, got.max_x, got.max_y, got.max_z};
            w = '{want.min_x, want.min_y, want.min_z, want.max_x, want.max_y, want.max_z};
            for (int i = 0; i < 6; i++) begin
                if (g[i] !== w[i])
                    report_mismatch($sformatf("%s got %0d want %0d", names[i],
                                              $signed(g[i]), $signed(w[i])));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [COORD_W-1:0]     i_cfg_data;

    qpbb_stream_if #(.t_payload(t_vertex)) vtx_ch ();
    qpbb_stream_if #(.t_payload(t_box))    box_ch ();

    chunk_box_tracker tracker = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    quantized_position_bounding_box i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vtx_ch),
        .o_box      (box_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Both channels are watched at the rising edge, before the block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (vtx_ch.valid && vtx_ch.ready) tracker.note_vertex(vtx_ch.data);
            if (box_ch.valid && box_ch.ready) tracker.check_box(box_ch.data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quantized_position_bounding_box_tb: errors");
            $finish;
        end
    end

    // Box receiver: random stalls, plus a long hold-off counted down here.
    initial begin
        box_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                box_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                box_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_vertex pack_vertex(logic [Q_W-1:0] x, logic [Q_W-1:0] y,
                                            logic [Q_W-1:0] z, logic l);
        t_vertex v;
        v.qx   = x;
        v.qy   = y;
        v.qz   = z;
        v.last = l;
        return v;
    endfunction

    function automatic logic [Q_W-1:0] pick_coord();
        logic [Q_W-1:0] edges [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        if ($urandom_range(9) == 0) return edges[$urandom_range(4)];
        return Q_W'($urandom);
    endfunction

    function automatic logic [COORD_W-1:0] pick_word(int kind);
        logic [COORD_W-1:0] edges [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                          32'h0000_0001, 32'hFFFF_FFFF, ONE_FIXED};
        case (kind)
            SET_UNITY:    return ONE_FIXED;
            SET_EXTREME:  return edges[$urandom_range(5)];
            SET_MODERATE: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            default:      return $urandom;
        endcase
    endfunction

    task automatic send_vertex(t_vertex v);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            vtx_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        vtx_ch.valid <= 1'b1;
        vtx_ch.data  <= v;
        do @(posedge i_clk); while (!vtx_ch.ready);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        tracker.set_register(idx, d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic write_setting(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                 logic [COORD_W-1:0] sz, logic [COORD_W-1:0] ox,
                                 logic [COORD_W-1:0] oy, logic [COORD_W-1:0] oz);
        write_register(CFG_SCALE_X, sx);
        write_register(CFG_SCALE_Y, sy);
        write_register(CFG_SCALE_Z, sz);
        write_register(CFG_OFFSET_X, ox);
        write_register(CFG_OFFSET_Y, oy);
        write_register(CFG_OFFSET_Z, oz);
    endtask

    // Lowers valid, waits for every pending box, then lets the pipe empty so that
    // a partial chunk has folded before any register changes.
    task automatic settle();
        @(negedge i_clk);
        vtx_ch.valid <= 1'b0;
        while (tracker.boxes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_chunks(int items, bit every_last);
        int chunk_left;
        chunk_left = 0;
        for (int i = 0; i < items; i++) begin
            if (chunk_left == 0)
                chunk_left = ($urandom_range(3) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, 8);
            chunk_left--;
            send_vertex(pack_vertex(pick_coord(), pick_coord(), pick_coord(),
                                    every_last || chunk_left == 0));
        end
    endtask

    initial begin
        int kinds [6];
        kinds        = '{SET_UNITY, SET_RANDOM, SET_EXTREME, SET_MODERATE,
                         SET_RANDOM, SET_EXTREME};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        vtx_ch.valid = 1'b0;
        vtx_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: single-vertex chunk, coordinate extremes, rounding near one.
        send_vertex(pack_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_vertex(pack_vertex(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0));
        send_vertex(pack_vertex(16'h8000, 16'h7FFF, 16'h0001, 1'b1));
        send_vertex(pack_vertex(16'h0001, 16'hFFFF, 16'd16383, 1'b0));
        send_vertex(pack_vertex(16'd16384, -16'sd16384, -16'sd16383, 1'b1));

        // A setting changed in the middle of a chunk keeps what was already folded.
        send_vertex(pack_vertex(16'd100, -16'sd200, 16'd300, 1'b0));
        settle();
        write_register(CFG_SCALE_X, 32'hFFFF_0000);
        write_register(CFG_OFFSET_Y, ONE_FIXED);
        send_vertex(pack_vertex(16'd100, -16'sd200, 16'd300, 1'b1));
        settle();

        // Extreme scales and offsets drive the sum into both saturation limits.
        write_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        write_register(CFG_IDX_SPARE_LO, 32'h1234_5678);
        write_register(CFG_IDX_SPARE_HI, 32'hDEAD_BEEF);
        send_vertex(pack_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_vertex(pack_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_vertex(pack_vertex(16'h0001, 16'hFFFF, 16'h0000, 1'b1));
        settle();
        write_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
        send_vertex(pack_vertex(16'h8000, 16'h8000, 16'h7FFF, 1'b1));
        send_vertex(pack_vertex(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1));
        settle();

        // Scale of one ulp: quotients straddle one half, rounded away from zero.
        write_setting(32'h1, 32'h1, 32'h1, '0, '0, '0);
        send_vertex(pack_vertex(16'd16384, 16'd16383, -16'sd16384, 1'b0));
        send_vertex(pack_vertex(-16'sd16383, 16'h0000, 16'h0001, 1'b1));
        settle();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 37 : (p < 4) ? 87 : 0;
            recv_idle_pct = (p < 2) ? 87 : (p < 4) ? 37 : 0;
            write_setting(pick_word(kinds[p]), pick_word(kinds[p]), pick_word(kinds[p]),
                          (kinds[p] == SET_UNITY) ? '0 : pick_word(kinds[p]),
                          (kinds[p] == SET_UNITY) ? '0 : pick_word(kinds[p]),
                          (kinds[p] == SET_UNITY) ? '0 : pick_word(kinds[p]));
            run_chunks(PHASE_ITEMS, 1'b0);
            settle();
        end

        // Every vertex closes a chunk while the receiver holds off, so the box
        // output backs up and the block must stall its input.
        write_setting(pick_word(SET_MODERATE), pick_word(SET_MODERATE),
                      pick_word(SET_MODERATE), pick_word(SET_MODERATE),
                      pick_word(SET_MODERATE), pick_word(SET_MODERATE));
        hold_left = HOLD_CYCLES;
        run_chunks(PRESSURE_ITEMS, 1'b1);
        settle();

        if (tracker.errors == 0) begin
            $display("quantized_position_bounding_box_tb: clean");
        end else begin
            $display("quantized_position_bounding_box_tb: errors");
        end
        $finish;
    end

endmodule
